/* rtl/scaled_fp32_to_fp16_converter_defines.svh */
// Assertion macros for the scaled fp32 to fp16 converter.
// Used by the top level only; no other dependencies.
`ifndef SCALED_FP32_TO_FP16_CONVERTER_DEFINES_SVH
`define SCALED_FP32_TO_FP16_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SCF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define SCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Plain implication, also checked during reset
`define SCF_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/scf_pkg.sv */
// Shared constants and helper functions for the scaled fp32 to fp16 converter.
// No dependencies.
package scf_pkg;

   localparam int unsigned DefaultLanes = 8;
   localparam int unsigned Stages = 4;
   localparam logic [31:0] ScaleReset = 32'h3F80_0000;

   // Bit position-based count of leading zeros in a 24-bit word
   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] cnt;
      cnt = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) begin
            cnt = 5'(23 - i);
         end
      end
      return cnt;
   endfunction

   // Shift right with round to nearest even on the dropped bits
   function automatic logic [47:0] rne_shift(input logic [47:0] v, input logic [5:0] sh);
      logic [47:0] q;
      logic [47:0] rem;
      logic [47:0] h;
      q = v >> sh;
      rem = v & ((48'h1 << sh) - 48'h1);
      h = 48'h1 << (sh - 6'd1);
      if (sh > 6'd48) begin
         q = 48'h0;
      end else if (rem > h || (rem == h && q[0])) begin
         q = q + 48'h1;
      end
      return q;
   endfunction

endpackage

/* rtl/scf_lane.sv */
// One lane of the converter: fp32 multiply then fp32 to fp16, four register stages.
// Depends on scf_pkg.
module scf_lane (
   input  logic                       clock,
   input  logic [scf_pkg::Stages-1:0] stage_en,
   input  logic [31:0]                value,
   input  logic [31:0]                scale,
   output logic [15:0]                half
);
   import scf_pkg::*;

   // stage 1: decode, specials, normalize subnormal operands
   logic              s1_sign_ff, s1_sign_in;
   logic signed [11:0] s1_ea_ff, s1_ea_in, s1_eb_ff, s1_eb_in;
   logic [23:0]       s1_ma_ff, s1_ma_in, s1_mb_ff, s1_mb_in;
   logic              s1_byp_ff, s1_byp_in;
   logic [31:0]       s1_bval_ff, s1_bval_in;

   logic [7:0]  ea_raw, eb_raw;
   logic [22:0] ma_raw, mb_raw;
   logic        za, zb;
   logic [4:0]  lza, lzb;

   always_comb begin
      ea_raw = value[30:23];
      eb_raw = scale[30:23];
      ma_raw = value[22:0];
      mb_raw = scale[22:0];
      za = (ea_raw == 8'd0) && (ma_raw == 23'd0);
      zb = (eb_raw == 8'd0) && (mb_raw == 23'd0);
      s1_sign_in = value[31] ^ scale[31];
      s1_byp_in = 1'b1;
      s1_bval_in = {s1_sign_in, 31'd0};
      if (ea_raw == 8'hFF && ma_raw != 23'd0) begin
         s1_bval_in = value | 32'h0040_0000;
      end else if (eb_raw == 8'hFF && mb_raw != 23'd0) begin
         s1_bval_in = scale | 32'h0040_0000;
      end else if (ea_raw == 8'hFF || eb_raw == 8'hFF) begin
         s1_bval_in = (za || zb) ? 32'hFFC0_0000 : {s1_sign_in, 31'h7F80_0000};
      end else if (za || zb) begin
         s1_bval_in = {s1_sign_in, 31'd0};
      end else begin
         s1_byp_in = 1'b0;
      end
      lza = lzc24({1'b0, ma_raw});
      lzb = lzc24({1'b0, mb_raw});
      if (ea_raw == 8'd0) begin
         s1_ma_in = {1'b0, ma_raw} << lza;
         s1_ea_in = 12'sd1 - signed'({7'd0, lza});
      end else begin
         s1_ma_in = {1'b1, ma_raw};
         s1_ea_in = signed'({4'd0, ea_raw});
      end
      if (eb_raw == 8'd0) begin
         s1_mb_in = {1'b0, mb_raw} << lzb;
         s1_eb_in = 12'sd1 - signed'({7'd0, lzb});
      end else begin
         s1_mb_in = {1'b1, mb_raw};
         s1_eb_in = signed'({4'd0, eb_raw});
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_sign_ff <= s1_sign_in;
         s1_ea_ff   <= s1_ea_in;
         s1_eb_ff   <= s1_eb_in;
         s1_ma_ff   <= s1_ma_in;
         s1_mb_ff   <= s1_mb_in;
         s1_byp_ff  <= s1_byp_in;
         s1_bval_ff <= s1_bval_in;
      end
   end

   // stage 2: significand product and exponent sum
   logic               s2_sign_ff;
   logic signed [11:0] s2_esum_ff, s2_esum_in;
   logic [47:0]        s2_prod_ff, s2_prod_in;
   logic               s2_byp_ff;
   logic [31:0]        s2_bval_ff;

   assign s2_prod_in = 48'(s1_ma_ff) * 48'(s1_mb_ff);
   assign s2_esum_in = s1_ea_ff + s1_eb_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_sign_ff <= s1_sign_ff;
         s2_esum_ff <= s2_esum_in;
         s2_prod_ff <= s2_prod_in;
         s2_byp_ff  <= s1_byp_ff;
         s2_bval_ff <= s1_bval_ff;
      end
   end

   // stage 3: normalize and round the product to fp32
   logic [31:0]        s3_f32_ff, s3_f32_in;
   logic signed [11:0] e3, extra3;
   logic [47:0]        p3, q3;
   logic [5:0]         sh3;
   logic [7:0]         eb3;
   logic [32:0]        enc3;

   always_comb begin
      if (s2_prod_ff[47]) begin
         p3 = s2_prod_ff;
         e3 = s2_esum_ff - 12'sd126;
      end else begin
         p3 = s2_prod_ff << 1;
         e3 = s2_esum_ff - 12'sd127;
      end
      extra3 = 12'sd1 - e3;
      sh3 = 6'd24;
      eb3 = e3[7:0] - 8'd1;
      if (e3 < 12'sd1) begin
         sh3 = (extra3 > 12'sd36) ? 6'd60 : 6'd24 + extra3[5:0];
         eb3 = 8'd0;
      end
      q3 = rne_shift(p3, sh3);
      enc3 = {2'b0, eb3, 23'd0} + {8'd0, q3[24:0]};
      if (s2_byp_ff) begin
         s3_f32_in = s2_bval_ff;
      end else if (e3 >= 12'sd255 || enc3 >= 33'h0_7F80_0000) begin
         s3_f32_in = {s2_sign_ff, 31'h7F80_0000};
      end else begin
         s3_f32_in = {s2_sign_ff, enc3[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_f32_ff <= s3_f32_in;
      end
   end

   // stage 4: fp32 to fp16 with round to nearest even
   logic [15:0]        s4_half_ff, s4_half_in;
   logic               sg4;
   logic [7:0]         e4;
   logic [22:0]        m4;
   logic [23:0]        sig4;
   logic signed [11:0] h4, extra4;
   logic [5:0]         sh4;
   logic [4:0]         hb4;
   logic [47:0]        q4;
   logic [16:0]        enc4;

   always_comb begin
      sg4 = s3_f32_ff[31];
      e4 = s3_f32_ff[30:23];
      m4 = s3_f32_ff[22:0];
      sig4 = (e4 == 8'd0) ? {1'b0, m4} : {1'b1, m4};
      h4 = ((e4 == 8'd0) ? 12'sd1 : signed'({4'd0, e4})) - 12'sd112;
      extra4 = 12'sd1 - h4;
      sh4 = 6'd13;
      hb4 = h4[4:0] - 5'd1;
      if (h4 < 12'sd1) begin
         sh4 = (extra4 > 12'sd47) ? 6'd60 : 6'd13 + extra4[5:0];
         hb4 = 5'd0;
      end
      q4 = rne_shift({24'd0, sig4}, sh4);
      enc4 = {2'b0, hb4, 10'd0} + {5'd0, q4[11:0]};
      if (e4 == 8'hFF) begin
         s4_half_in = (m4 == 23'd0) ? {sg4, 15'h7C00} : {sg4, 15'h7E00 | {5'd0, m4[22:13]}};
      end else if (e4 == 8'd0 && m4 == 23'd0) begin
         s4_half_in = {sg4, 15'd0};
      end else if (h4 >= 12'sd31 || enc4 >= 17'h0_7C00) begin
         s4_half_in = {sg4, 15'h7C00};
      end else begin
         s4_half_in = {sg4, enc4[14:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_half_ff <= s4_half_in;
      end
   end

   assign half = s4_half_ff;

endmodule

/* rtl/scaled_fp32_to_fp16_converter.sv */
// Scaled fp32 to fp16 converter, LANES lanes per item.
// Items pass the stages decode, multiply, fp32 round and fp16 round between input accept
// and result accept, each stage a register per lane. Throughput: one item per cycle while
// rsp_tready is high. Stages advance independently, so bubbles close up under output stall.
// Synchronous active-high reset clears the stage valid bits and sets the scale to 1.0.
module scaled_fp32_to_fp16_converter #(
   parameter int unsigned LANES = scf_pkg::DefaultLanes
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [LANES*32-1:0]  req_tdata,   // value_0 .. value_(LANES-1), 32 bits each
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [LANES*16-1:0]  rsp_tdata,   // half_0 .. half_(LANES-1), 16 bits each
   output logic                 rsp_tlast,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data
);
   import scf_pkg::*;
   `include "scaled_fp32_to_fp16_converter_defines.svh"

   logic [31:0]       scale_ff;
   logic [Stages-1:0] valid_ff, valid_in;
   logic [Stages-1:0] last_ff;
   logic [Stages-1:0] stage_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= ScaleReset;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // a stage loads when it is empty or its content moves on
   always_comb begin
      stage_en[Stages-1] = !valid_ff[Stages-1] || rsp_tready;
      for (int k = Stages - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = req_tvalid;
      for (int k = 1; k < Stages; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         last_ff[0] <= req_tlast;
      end
      for (int k = 1; k < Stages; k++) begin
         if (stage_en[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      scf_lane u_lane (
         .clock    (clock),
         .stage_en (stage_en),
         .value    (req_tdata[i*32 +: 32]),
         .scale    (scale_ff),
         .half     (rsp_tdata[i*16 +: 16])
      );
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[Stages-1];
   assign rsp_tlast  = last_ff[Stages-1];

   `SCF_ASSERT_NEXT(a_accept_fills, clock, reset, req_tvalid && req_tready, valid_ff[0], "accepted item missing from first stage")
   `SCF_ASSERT_NOW(a_full_stall, clock, reset, (&valid_ff) && !rsp_tready, !req_tready, "input taken while pipeline is full and stalled")
   `SCF_ASSERT_NEXT(a_scale_reset, clock, 1'b0, reset, scale_ff == ScaleReset, "scale not restored by reset")

endmodule
